// ===== sv/multi_rate_tick_event_table_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multi-rate tick event table
// Shared concurrent-check forms, clocked and reset-qualified in one place.
// ----------------------------------------------------------------------------
`ifndef MULTI_RATE_TICK_EVENT_TABLE_ASSERT_SVH
`define MULTI_RATE_TICK_EVENT_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MRTE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define MRTE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");

`endif

// ===== sv/mrte_pkg.sv =====
// ----------------------------------------------------------------------------
// mrte_pkg
// Codes, field widths and state encoding for the tick event table.
// ----------------------------------------------------------------------------
package mrte_pkg;

    localparam int CMD_W   = 2;
    localparam int FREQ_W  = 16;
    localparam int SLOT_W  = 3;
    localparam int COUNT_W = 24;
    localparam int STAT_W  = 2;
    localparam int FLAGS_W = 8;
    localparam int PROD_W  = COUNT_W + FREQ_W;
    localparam int FRAC_W  = 15;   // counter ticks at 32768 Hz

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_UNUSED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SWEEP  = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

endpackage

// ===== sv/mrte_ram.sv =====
// ----------------------------------------------------------------------------
// mrte_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mrte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/multi_rate_tick_event_table.sv =====
// ----------------------------------------------------------------------------
// multi_rate_tick_event_table
// Periodic event slots paced by a shared 32768 Hz real-time counter.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_tvalid/s_tready; s_tuser carries the command
//   (create, free, tick, clear flag), s_tdata the frequency, slot and counter.
//   Each beat yields exactly one result beat on m_tvalid/m_tready carrying
//   the slot given, a status and the low eight event flags.
// Throughput:
//   Create, free and clear finish in the accepting cycle; the result is
//   registered and shows on the next cycle, so one such beat per cycle
//   while the receiver takes results. A tick sweeps the frequency and count
//   memories one slot per cycle through a read / multiply / compare-and-write
//   pipeline, and its result is loaded once the pipeline has drained.
// Reset:
//   aresetn (synchronous, active low) clears every valid bit and flag and
//   empties the pipeline. Frequency and count memories are not cleared;
//   create writes them before any tick acts on them.
// Stalls:
//   A pending result is held on m_tdata until taken. The next beat is
//   accepted in the cycle the held result drains, so a stalled receiver
//   stalls the input side by exactly that long.
// ----------------------------------------------------------------------------
`include "multi_rate_tick_event_table_assert.svh"

module multi_rate_tick_event_table #(
    parameter int SLOTS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [15:0] frequency, [18:16] slot, [42:19] counter, [47:43] zero
    input  logic [mrte_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] command
    input  logic [mrte_pkg::CMD_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] slot_given, [4:3] status, [12:5] flags, [15:13] zero
    output logic [mrte_pkg::M_TDATA_W-1:0]  m_tdata
);

    import mrte_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam int RES_W = SLOT_W + STAT_W + FLAGS_W;

    // Input field split
    cmd_t                in_cmd;
    logic [FREQ_W-1:0]   in_freq;
    logic [SLOT_W-1:0]   in_slot;
    logic [COUNT_W-1:0]  in_counter;

    assign in_cmd     = cmd_t'(s_tuser);
    assign in_freq    = s_tdata[FREQ_W-1:0];
    assign in_slot    = s_tdata[FREQ_W+SLOT_W-1:FREQ_W];
    assign in_counter = s_tdata[FREQ_W+SLOT_W+COUNT_W-1:FREQ_W+SLOT_W];

    // Control state
    state_t              state_reg, state_next;
    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic [SLOTS-1:0]    flag_reg, flag_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                s1_vld_reg, s1_vld_next;
    logic                s2_vld_reg, s2_vld_next;
    logic                m_valid_reg, m_valid_next;

    // Payload
    logic [COUNT_W-1:0]  counter_reg, counter_next;
    logic [SLOT_W-1:0]   tick_slot_reg, tick_slot_next;
    logic [IDX_W-1:0]    s1_idx_reg, s1_idx_next;
    logic [IDX_W-1:0]    s2_idx_reg, s2_idx_next;
    logic [COUNT_W-1:0]  s2_q_reg, s2_q_next;
    logic [COUNT_W-1:0]  s2_count_reg, s2_count_next;
    logic [RES_W-1:0]    m_data_reg, m_data_next;

    // Memory ports
    logic                freq_we;
    logic [IDX_W-1:0]    freq_waddr;
    logic [FREQ_W-1:0]   freq_wdata;
    logic [FREQ_W-1:0]   freq_rdata;
    logic                count_we;
    logic [IDX_W-1:0]    count_waddr;
    logic [COUNT_W-1:0]  count_wdata;
    logic [COUNT_W-1:0]  count_rdata;

    // Helpers
    logic                accept;
    logic                out_free;
    logic                free_found;
    logic [IDX_W-1:0]    free_idx;
    logic                slot_in_range;
    logic [IDX_W-1:0]    slot_idx;
    logic                slot_used;
    logic [PROD_W-1:0]   prod;
    logic                out_load;
    logic [SLOT_W-1:0]   out_given;
    status_t             out_status;
    logic [SLOTS+FLAGS_W-1:0] flag_wide;

    mrte_ram #(.WIDTH(FREQ_W), .DEPTH(SLOTS)) u_freq_ram (
        .aclk  (aclk),
        .we    (freq_we),
        .waddr (freq_waddr),
        .wdata (freq_wdata),
        .raddr (rd_idx_reg),
        .rdata (freq_rdata)
    );

    mrte_ram #(.WIDTH(COUNT_W), .DEPTH(SLOTS)) u_count_ram (
        .aclk  (aclk),
        .we    (count_we),
        .waddr (count_waddr),
        .wdata (count_wdata),
        .raddr (rd_idx_reg),
        .rdata (count_rdata)
    );

    // Handshake: take a beat only when idle and the result register can drain.
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // Lowest free slot for create.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign slot_in_range = int'(in_slot) < SLOTS;
    assign slot_idx      = IDX_W'(in_slot);
    assign slot_used     = slot_in_range && valid_reg[slot_idx];

    // Stage 1: scale the read frequency by the counter; keep the 24-bit quotient.
    assign prod = PROD_W'(counter_reg) * PROD_W'(freq_rdata);

    always_comb begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        flag_next      = flag_reg;
        rd_idx_next    = rd_idx_reg;
        counter_next   = counter_reg;
        tick_slot_next = tick_slot_reg;

        s1_vld_next    = 1'b0;
        s1_idx_next    = rd_idx_reg;
        s2_vld_next    = s1_vld_reg;
        s2_idx_next    = s1_idx_reg;
        s2_q_next      = prod[FRAC_W+COUNT_W-1:FRAC_W];
        s2_count_next  = count_rdata;

        freq_we        = 1'b0;
        freq_waddr     = free_idx;
        freq_wdata     = in_freq;
        count_we       = 1'b0;
        count_waddr    = free_idx;
        count_wdata    = '0;

        out_load       = 1'b0;
        out_given      = in_slot;
        out_status     = STAT_OK;

        // Stage 2: on a change, raise the flag and write back the new count.
        if (s2_vld_reg && valid_reg[s2_idx_reg] && (s2_q_reg != s2_count_reg)) begin
            flag_next[s2_idx_reg] = 1'b1;
            count_we              = 1'b1;
            count_waddr           = s2_idx_reg;
            count_wdata           = s2_q_reg;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (in_cmd) inside
                        CMD_CREATE: begin
                            out_load = 1'b1;
                            if (free_found) begin
                                valid_next[free_idx] = 1'b1;
                                flag_next[free_idx]  = 1'b0;
                                freq_we              = 1'b1;
                                count_we             = 1'b1;
                                out_given            = SLOT_W'(free_idx);
                            end else begin
                                out_status = STAT_FULL;
                            end
                        end
                        CMD_TICK: begin
                            state_next     = ST_SWEEP;
                            rd_idx_next    = '0;
                            counter_next   = in_counter;
                            tick_slot_next = in_slot;
                        end
                        CMD_FREE, CMD_CLEAR: begin
                            out_load = 1'b1;
                            if (!slot_used) begin
                                out_status = STAT_UNUSED;
                            end else begin
                                flag_next[slot_idx] = 1'b0;
                                if (in_cmd == CMD_FREE) begin
                                    valid_next[slot_idx] = 1'b0;
                                end
                            end
                        end
                        default: begin
                            out_load = 1'b0;
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                // Issue one memory read per cycle.
                s1_vld_next = 1'b1;
                if (rd_idx_reg == LAST_IDX) begin
                    state_next = ST_FINISH;
                end else begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                // Wait for the pipeline to drain and the result register to free up.
                if (!s1_vld_reg && !s2_vld_reg && out_free) begin
                    out_load   = 1'b1;
                    out_given  = tick_slot_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        flag_wide    = {{FLAGS_W{1'b0}}, flag_next};
        m_data_next  = {flag_wide[FLAGS_W-1:0], out_status, out_given};
        m_valid_next = out_load || (m_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            flag_reg    <= '0;
            rd_idx_reg  <= '0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            flag_reg    <= flag_next;
            rd_idx_reg  <= rd_idx_next;
            s1_vld_reg  <= s1_vld_next;
            s2_vld_reg  <= s2_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        counter_reg   <= counter_next;
        tick_slot_reg <= tick_slot_next;
        s1_idx_reg    <= s1_idx_next;
        s2_idx_reg    <= s2_idx_next;
        s2_q_reg      <= s2_q_next;
        s2_count_reg  <= s2_count_next;
        if (out_load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - RES_W){1'b0}}, m_data_reg};

    // Checks
    `MRTE_ASSERT_NOW(a_ready_pipe_empty, aclk, aresetn, s_tready, !s1_vld_reg && !s2_vld_reg)
    `MRTE_ASSERT_NOW(a_wb_not_idle, aclk, aresetn, s2_vld_reg, state_reg != ST_IDLE)
    `MRTE_ASSERT_NEXT(a_cmd_result, aclk, aresetn, accept && (in_cmd != CMD_TICK), m_valid_reg)
    `MRTE_ASSERT_NEXT(a_sweep_reads, aclk, aresetn, state_reg == ST_SWEEP, s1_vld_reg)

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the tick event table with creates, frees, counter ticks and flag
// clears: directed rows first, then a long random stream. A software copy of
// the table predicts each result beat but hand-typed directed ones; the beats
// are checked field by field in order. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mrte_pkg::*;

    localparam int TABLE_SLOTS  = 8;
    localparam int RANDOM_BEATS = 1700;
    localparam int TAIL_BEATS   = 150;    // final stretch runs without idling
    localparam int SETTLE       = TABLE_SLOTS + 8;

    // result fields, last field in the low bits as on m_tdata
    typedef struct packed {
        logic [FLAGS_W-1:0] flags;
        status_t            status;
        logic [SLOT_W-1:0]  slot_given;
    } result_t;

    typedef struct {
        cmd_t                cmd;
        logic [FREQ_W-1:0]   freq;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  counter;
        bit                  typed;   // result written out by hand
        result_t             want;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // [15:0] frequency, [18:16] slot, [42:19] counter, [47:43] zero
    logic [S_TDATA_W-1:0]  s_tdata;
    // [1:0] command
    logic [CMD_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // [2:0] slot_given, [4:3] status, [12:5] flags, [15:13] zero
    logic [M_TDATA_W-1:0]  m_tdata;

    // Shadow copy of the slot table.
    logic                slot_live  [TABLE_SLOTS];
    logic [FREQ_W-1:0]   slot_rate  [TABLE_SLOTS];
    logic [COUNT_W-1:0]  slot_count [TABLE_SLOTS];
    logic                slot_event [TABLE_SLOTS];

    result_t   pending_results[$];
    stim_row_t directed_rows[$];
    result_t   oldest;

    bit          steady_tail;
    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned n_create, n_full, n_free, n_tick, n_clear, n_rises;

    multi_rate_tick_event_table #(
        .SLOTS    (TABLE_SLOTS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop well past the slowest legal run (about 0.3 ms).
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at result %0d: %s got %0h, expected %0h",
                     results_checked, what, got, want);
    endtask

    // Apply one command to the shadow table and return the beat it yields.
    function automatic result_t table_step(cmd_t c, logic [FREQ_W-1:0] f,
                                          logic [SLOT_W-1:0] s,
                                          logic [COUNT_W-1:0] ctr);
        result_t           r;
        logic [PROD_W-1:0] prod;
        logic [COUNT_W-1:0] q;
        r.slot_given = s;
        r.status     = STAT_OK;
        r.flags      = '0;
        case (c)
            CMD_CREATE: begin
                n_create++;
                r.status = STAT_FULL;
                // take the lowest free slot
                for (int i = 0; i < TABLE_SLOTS; i++) begin
                    if (r.status == STAT_FULL && !slot_live[i]) begin
                        slot_live[i]  = 1'b1;
                        slot_rate[i]  = f;
                        slot_count[i] = '0;
                        slot_event[i] = 1'b0;
                        r.slot_given  = SLOT_W'(i);
                        r.status      = STAT_OK;
                    end
                end
                if (r.status == STAT_FULL)
                    n_full++;
            end
            CMD_TICK: begin
                n_tick++;
                for (int i = 0; i < TABLE_SLOTS; i++) begin
                    if (slot_live[i]) begin
                        // full-width product, quotient kept to the count width
                        prod = PROD_W'(ctr) * PROD_W'(slot_rate[i]);
                        q    = prod[FRAC_W +: COUNT_W];
                        if (q != slot_count[i]) begin
                            slot_event[i] = 1'b1;
                            slot_count[i] = q;
                            n_rises++;
                        end
                    end
                end
            end
            default: begin
                if (c == CMD_FREE)
                    n_free++;
                else
                    n_clear++;
                if (!slot_live[s]) begin
                    r.status = STAT_UNUSED;
                end else begin
                    // free also drops the slot's flag
                    if (c == CMD_FREE)
                        slot_live[s] = 1'b0;
                    slot_event[s] = 1'b0;
                end
            end
        endcase
        for (int i = 0; i < FLAGS_W && i < TABLE_SLOTS; i++)
            r.flags[i] = slot_event[i];
        return r;
    endfunction

    // Pick a live slot most of the time, any index otherwise.
    function automatic logic [SLOT_W-1:0] pick_target();
        logic [SLOT_W-1:0] live[$];
        for (int i = 0; i < TABLE_SLOTS; i++)
            if (slot_live[i])
                live.push_back(SLOT_W'(i));
        if (live.size() == 0 || $urandom_range(0, 3) == 0)
            return SLOT_W'($urandom_range(0, 7));
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    function automatic logic [FREQ_W-1:0] pick_rate();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        if (roll < 15)
            return FREQ_W'($urandom_range(32769, 65535));
        return FREQ_W'($urandom_range(1, 32768));
    endfunction

    function automatic void add_row(cmd_t c, logic [FREQ_W-1:0] f,
                                    logic [SLOT_W-1:0] s, logic [COUNT_W-1:0] ctr,
                                    bit typed = 1'b0, logic [SLOT_W-1:0] given = '0,
                                    status_t st = STAT_OK, logic [FLAGS_W-1:0] flg = '0);
        stim_row_t row;
        row.cmd             = c;
        row.freq            = f;
        row.slot            = s;
        row.counter         = ctr;
        row.typed           = typed;
        row.want.slot_given = given;
        row.want.status     = st;
        row.want.flags      = flg;
        directed_rows.push_back(row);
    endfunction

    // Present one beat at the falling edge, hold it until accepted, then
    // record what the table should answer.
    int unsigned send_calm;
    task automatic drive_beat(cmd_t c, logic [FREQ_W-1:0] f, logic [SLOT_W-1:0] s,
                              logic [COUNT_W-1:0] ctr, bit typed, result_t typed_result);
        result_t predicted;
        if (!steady_tail) begin
            if (send_calm > 0) begin
                send_calm--;
            end else if ($urandom_range(0, 3) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge aclk);
            end else if ($urandom_range(0, 19) == 0) begin
                send_calm = $urandom_range(20, 80);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {5'b0, ctr, s, f};
        do @(posedge aclk); while (s_tready !== 1'b1);
        predicted = table_step(c, f, s, ctr);
        pending_results.push_back(typed ? typed_result : predicted);
        @(negedge aclk);
    endtask

    // Result side: random stall bursts, calm stretches, none in the tail.
    initial begin
        int unsigned stall_left;
        int unsigned calm_left;
        stall_left = 0;
        calm_left  = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                stall_left--;
            end else if (calm_left > 0) begin
                calm_left--;
            end else if (!steady_tail) begin
                case ($urandom_range(0, 15))
                    0, 1:    stall_left = $urandom_range(1, 14);
                    2:       calm_left  = $urandom_range(20, 120);
                    default: ;
                endcase
            end
            if (steady_tail)
                stall_left = 0;
            m_tready <= (stall_left == 0);
        end
    end

    // Check each accepted result beat against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", 32'(m_tdata), 32'h0);
            end else begin
                oldest = pending_results.pop_front();
                if (m_tdata[2:0] !== oldest.slot_given)
                    report_mismatch("slot_given", 32'(m_tdata[2:0]), 32'(oldest.slot_given));
                if (m_tdata[4:3] !== oldest.status)
                    report_mismatch("status", 32'(m_tdata[4:3]), 32'(oldest.status));
                if (m_tdata[12:5] !== oldest.flags)
                    report_mismatch("flags", 32'(m_tdata[12:5]), 32'(oldest.flags));
            end
            results_checked++;
        end
    end

    initial begin
        logic [COUNT_W-1:0] rtc;
        cmd_t               c;
        int unsigned        roll;
        result_t            none;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_CREATE;
        none     = '0;
        rtc      = '0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            slot_live[i]  = 1'b0;
            slot_rate[i]  = '0;
            slot_count[i] = '0;
            slot_event[i] = 1'b0;
        end

        // Empty table: free, clear and tick touch nothing.
        add_row(CMD_FREE,   16'd0,     3'd3, 24'd0,      1'b1, 3'd3, STAT_UNUSED, 8'h00);
        add_row(CMD_CLEAR,  16'hFFFF,  3'd7, 24'd0,      1'b1, 3'd7, STAT_UNUSED, 8'h00);
        add_row(CMD_TICK,   16'd0,     3'd5, 24'd0,      1'b1, 3'd5, STAT_OK,     8'h00);
        // Fill every slot, frequency extremes included, then overflow.
        add_row(CMD_CREATE, 16'd1,     3'd6, 24'd0,      1'b1, 3'd0, STAT_OK,     8'h00);
        add_row(CMD_CREATE, 16'd32768, 3'd0, 24'd0,      1'b1, 3'd1, STAT_OK,     8'h00);
        add_row(CMD_CREATE, 16'd0,     3'd0, 24'd0,      1'b1, 3'd2, STAT_OK,     8'h00);
        add_row(CMD_CREATE, 16'hFFFF,  3'd0, 24'hFFFFFF, 1'b1, 3'd3, STAT_OK,     8'h00);
        add_row(CMD_CREATE, 16'd1000,  3'd0, 24'd0,      1'b1, 3'd4, STAT_OK,     8'h00);
        add_row(CMD_CREATE, 16'd50,    3'd0, 24'd0,      1'b1, 3'd5, STAT_OK,     8'h00);
        add_row(CMD_CREATE, 16'd32767, 3'd0, 24'd0,      1'b1, 3'd6, STAT_OK,     8'h00);
        add_row(CMD_CREATE, 16'd7,     3'd0, 24'd0,      1'b1, 3'd7, STAT_OK,     8'h00);
        add_row(CMD_CREATE, 16'd9,     3'd2, 24'd0,      1'b1, 3'd2, STAT_FULL,   8'h00);
        // Full-scale tick wraps the largest quotient; a repeat changes nothing.
        add_row(CMD_TICK,   16'd0,     3'd0, 24'hFFFFFF);
        add_row(CMD_TICK,   16'd0,     3'd1, 24'hFFFFFF);
        add_row(CMD_CLEAR,  16'd0,     3'd3, 24'd0);
        add_row(CMD_CLEAR,  16'd0,     3'd2, 24'd0);
        add_row(CMD_FREE,   16'd0,     3'd4, 24'd0);
        add_row(CMD_FREE,   16'd0,     3'd4, 24'd0);
        add_row(CMD_CLEAR,  16'd0,     3'd4, 24'd0);
        add_row(CMD_CREATE, 16'd12345, 3'd1, 24'd0);
        add_row(CMD_TICK,   16'd0,     3'd7, 24'd1);
        add_row(CMD_TICK,   16'd0,     3'd0, 24'd32768);
        add_row(CMD_FREE,   16'd0,     3'd7, 24'd0);
        add_row(CMD_CLEAR,  16'd0,     3'd0, 24'd0);
        add_row(CMD_TICK,   16'd0,     3'd2, 24'h800000);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            drive_beat(directed_rows[i].cmd, directed_rows[i].freq, directed_rows[i].slot,
                       directed_rows[i].counter, directed_rows[i].typed,
                       directed_rows[i].want);

        // Random stream: the counter mostly advances in small steps like a real
        // clock, with occasional jumps; free and clear mostly hit live slots.
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n == RANDOM_BEATS - TAIL_BEATS)
                steady_tail = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 20)
                c = CMD_CREATE;
            else if (roll < 35)
                c = CMD_FREE;
            else if (roll < 75)
                c = CMD_TICK;
            else
                c = CMD_CLEAR;
            if (c == CMD_TICK) begin
                if ($urandom_range(0, 6) == 0)
                    rtc = COUNT_W'($urandom);
                else
                    rtc = rtc + COUNT_W'($urandom_range(0, 4096));
            end
            drive_beat(c,
                       c == CMD_CREATE ? pick_rate() : FREQ_W'($urandom),
                       (c == CMD_FREE || c == CMD_CLEAR) ? pick_target()
                                                          : SLOT_W'($urandom_range(0, 7)),
                       c == CMD_TICK ? rtc : COUNT_W'($urandom),
                       1'b0, none);
        end
        s_tvalid <= 1'b0;

        // Drain, then give a late or extra beat time to show up.
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        $display("covered %0d creates (%0d on a full table), %0d frees, %0d ticks, %0d clears",
                 n_create, n_full, n_free, n_tick, n_clear);
        $display("checked %0d result beats, %0d slot flag rises predicted",
                 results_checked, n_rises);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
